[sv/slidr_pkg.sv]
package slidr_pkg;

  // Number of cells in the chain, one stored value per cell.
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int OP_W     = 2;
  localparam int POS_W    = 4;
  localparam int OCNT_W   = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic             vld;
    logic             after;
    logic [VAL_W-1:0] val;
  } cell_link_t;

endpackage

[sv/slidr_cell.sv]
module slidr_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  slidr_pkg::cell_ctrl_t  ctrl_i,
  input  slidr_pkg::cell_link_t  left_i,
  input  slidr_pkg::cell_link_t  right_i,
  input  logic                   del_here_i,
  output slidr_pkg::cell_link_t  link_o
);

  logic [slidr_pkg::VAL_W-1:0] val_q, val_d;
  logic                        vld_q, vld_d;
  logic                        after;

  // The new value belongs at or ahead of this cell when the cell is empty
  // or holds a strictly greater value.
  assign after = !vld_q || ($signed(val_q) > $signed(ctrl_i.value));

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctrl_i.ins) begin
      if (left_i.after) begin
        val_d = left_i.val;
        vld_d = left_i.vld;
      end else if (after) begin
        val_d = ctrl_i.value;
        vld_d = 1'b1;
      end
    end else if (ctrl_i.del && del_here_i) begin
      val_d = right_i.val;
      vld_d = right_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign link_o.vld   = vld_q;
  assign link_o.after = after;
  assign link_o.val   = val_q;

endmodule

[sv/sorted_list_insert_delete_read.sv]
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    opcode_i, value_i, position_i
// out      output     out_valid_o / out_stall_i  read_value_o, ok_o, count_o
//
// One beat is taken per cycle unless the input stalls; its result appears in
// the output register on the next cycle. The rate is set by the cell chain,
// where every cell compares and shifts in parallel.
// Reset (rst_ni low) empties the store and drops any pending result.
// The input stalls only while a result waits and the output is stalled.
module sorted_list_insert_delete_read (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [slidr_pkg::OP_W-1:0]    opcode_i,
  input  logic signed [slidr_pkg::VAL_W-1:0] value_i,
  input  logic [slidr_pkg::POS_W-1:0]   position_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [slidr_pkg::VAL_W-1:0] read_value_o,
  output logic                          ok_o,
  output logic [slidr_pkg::OCNT_W-1:0]  count_o
);

  localparam int N = slidr_pkg::CAPACITY;

  slidr_pkg::cell_link_t links [N];
  slidr_pkg::cell_link_t left  [N];
  slidr_pkg::cell_link_t right [N];
  logic [N-1:0]          del_here;
  slidr_pkg::cell_ctrl_t ctrl;

  logic [slidr_pkg::CNT_W-1:0] count_q, count_d;
  logic                        in_acc;
  logic                        full;
  logic                        hit;
  logic [slidr_pkg::VAL_W-1:0] hit_val;
  logic                        ok;
  logic [slidr_pkg::VAL_W-1:0] rd;

  logic                        out_valid_q, out_valid_d;
  logic [slidr_pkg::VAL_W-1:0] read_value_q;
  logic                        ok_q;
  logic [slidr_pkg::OCNT_W-1:0] count_out_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (count_q == slidr_pkg::CNT_W'(N));

  // Read lookup: only a valid cell at the requested position answers, which
  // also tells whether the position lies below the count.
  always_comb begin
    hit     = 1'b0;
    hit_val = '0;
    for (int i = 0; i < N; i++) begin
      if (links[i].vld && (32'(position_i) == i)) begin
        hit     = 1'b1;
        hit_val = hit_val | links[i].val;
      end
    end
  end

  always_comb begin
    ok = 1'b0;
    rd = '0;
    case (opcode_i)
      slidr_pkg::OP_INSERT: ok = !full;
      slidr_pkg::OP_DELETE: ok = hit;
      slidr_pkg::OP_READ: begin
        ok = hit;
        rd = hit_val;
      end
      default: ok = 1'b0;
    endcase
  end

  assign ctrl.ins   = in_acc && (opcode_i == slidr_pkg::OP_INSERT) && ok;
  assign ctrl.del   = in_acc && (opcode_i == slidr_pkg::OP_DELETE) && ok;
  assign ctrl.value = value_i;

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.del) begin
      count_d = count_q - 1'b1;
    end
  end

  // The chain: each cell sees its left and right neighbors. The end cells
  // see an empty, never-after neighbor so that nothing shifts in from
  // outside the chain.
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left[i] = '0;
    end else begin : g_mid_l
      assign left[i] = links[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right[i] = '0;
    end else begin : g_mid_r
      assign right[i] = links[i+1];
    end
    assign del_here[i] = (32'(position_i) <= i);

    slidr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .left_i     (left[i]),
      .right_i    (right[i]),
      .del_here_i (del_here[i]),
      .link_o     (links[i])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; it only loads on an accepted beat, so it holds while
  // the output is stalled.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      read_value_q <= rd;
      ok_q         <= ok;
      count_out_q  <= slidr_pkg::OCNT_W'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign ok_o         = ok_q;
  assign count_o      = count_out_q;

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import slidr_pkg::*;

  // Opcode 3 has no function. The block must answer it with a failure and
  // leave the store alone.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // The receiver holds off for this many cycles during the back-pressure test.
  localparam int HOLD_CYCLES = 300;
  // The run is abandoned after this many cycles in which no beat moves on
  // either channel. This is far above the longest hold-off.
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_BEATS = 820;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    ok;
    logic [OCNT_W-1:0]       count;
  } result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [OP_W-1:0]         opcode = OP_READ;
  logic signed [VAL_W-1:0] value = '0;
  logic [POS_W-1:0]        position = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VAL_W-1:0] read_value;
  logic                    ok;
  logic [OCNT_W-1:0]       count;

  // This is a shadow copy of the sorted store. It is kept in step with the
  // block: every beat that is accepted on the input is applied here.
  logic signed [VAL_W-1:0] shadow_values [CAPACITY];
  int                      shadow_count = 0;

  // These are the results that have been predicted but not yet received, oldest first.
  result_t                 pending_results[$];

  int                      mismatches = 0;
  int                      burst_left = 0;
  int                      idle_cycles = 0;
  bit                      hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  sorted_list_insert_delete_read u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (opcode),
    .value_i      (value),
    .position_i   (position),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .read_value_o (read_value),
    .ok_o         (ok),
    .count_o      (count)
  );

  // This function applies one operation to the shadow store and returns the
  // result that the block must give for it. An insert goes just ahead of the
  // first stored value that is strictly greater. Equal values therefore keep
  // their arrival order. A full store, a position at or past the count, and
  // the unused opcode all leave the store unchanged and report a failure.
  function automatic result_t predict_result(logic [OP_W-1:0] op,
                                             logic signed [VAL_W-1:0] val,
                                             logic [POS_W-1:0] pos);
    result_t r;
    int      slot;
    int      i;
    r = '0;
    case (op)
      OP_INSERT: begin
        if (shadow_count < CAPACITY) begin
          slot = shadow_count;
          for (i = shadow_count - 1; i >= 0; i--)
            if (shadow_values[i] > val) slot = i;
          for (i = shadow_count; i > slot; i--)
            shadow_values[i] = shadow_values[i-1];
          shadow_values[slot] = val;
          shadow_count++;
          r.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (int'(pos) < shadow_count) begin
          for (i = int'(pos); i + 1 < shadow_count; i++)
            shadow_values[i] = shadow_values[i+1];
          shadow_count--;
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (int'(pos) < shadow_count) begin
          r.read_value = shadow_values[pos];
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = OCNT_W'(shadow_count);
    return r;
  endfunction

  // This task offers one beat and returns once the block has accepted it. The
  // sender works in bursts. Between bursts it drops valid for a random gap.
  // Some gaps are zero, so some stretches carry no idle cycles at all.
  task automatic send_beat(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] val,
                           logic [POS_W-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= val;
    position <= pos;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    pending_results.push_back(predict_result(op, val, pos));
  endtask

  // This function returns a value for an insert. Four draws in ten come from a
  // narrow band so that duplicates and near ties are common. The rest are the
  // two extremes, zero and minus one, or a full 32-bit random value.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3, 4: return $signed(32'($urandom_range(0, 20))) - 32'sd10;
      default: return $signed($urandom());
    endcase
  endfunction

  // This function returns a position. Most positions fall inside the stored
  // range. The rest are drawn from the whole field, so they also reach
  // positions at and past the count.
  function automatic logic [POS_W-1:0] pick_position();
    if (shadow_count > 0 && $urandom_range(0, 4) != 0)
      return POS_W'($urandom_range(0, shadow_count - 1));
    return POS_W'($urandom_range(0, 15));
  endfunction

  // The receiver works in phases of random length. A phase is either free
  // running, lightly stalled or heavily stalled. When the back-pressure test
  // asks for it, the receiver instead keeps stall high for a long stretch
  // and counts the cycles here.
  initial begin : receiver
    int phase_left;
    int stall_pct;
    phase_left = 0;
    stall_pct = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(10, 60);
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 25;
            default: stall_pct = 70;
          endcase
        end
        phase_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Each result beat is checked against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    result_t exp_r;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat arrived with no prediction pending");
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        if (read_value !== exp_r.read_value) begin
          $error("read_value: expected %0d, got %0d", exp_r.read_value, read_value);
          mismatches++;
        end
        if (ok !== exp_r.ok) begin
          $error("ok: expected %0b, got %0b", exp_r.ok, ok);
          mismatches++;
        end
        if (count !== exp_r.count) begin
          $error("count: expected %0d, got %0d", exp_r.count, count);
          mismatches++;
        end
      end
    end
  end

  // The watchdog ends a run that has hung on either handshake.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // On an empty store, every read and delete fails, whatever the position.
  // The unused opcode is tried here too.
  task automatic test_empty_store();
    send_beat(OP_READ, 32'sd0, 4'd0);
    send_beat(OP_DELETE, 32'sd0, 4'd0);
    send_beat(OP_READ, -32'sd1, 4'd15);
    send_beat(OP_UNUSED, 32'sh7fff_ffff, 4'd0);
  endtask

  // This test inserts the extremes of the value range and a pair of equal
  // values. It then reads at both ends, reads one place past the count, and
  // deletes from the middle.
  task automatic test_extreme_values();
    send_beat(OP_INSERT, 32'sh7fff_ffff, 4'd15);
    send_beat(OP_INSERT, 32'sh8000_0000, 4'd0);
    send_beat(OP_INSERT, 32'sd0, 4'd0);
    send_beat(OP_INSERT, -32'sd1, 4'd0);
    send_beat(OP_INSERT, 32'sd5, 4'd0);
    send_beat(OP_INSERT, 32'sd5, 4'd0);
    send_beat(OP_READ, 32'sd0, 4'd0);
    send_beat(OP_READ, 32'sd0, 4'd5);
    send_beat(OP_READ, 32'sd0, 4'd6);
    send_beat(OP_DELETE, 32'sd0, 4'd2);
  endtask

  // This test fills the store to capacity and then inserts once more, which
  // must fail. It then works on the last position and deletes the first.
  task automatic test_full_store();
    while (shadow_count < CAPACITY) send_beat(OP_INSERT, pick_value(), 4'd0);
    send_beat(OP_INSERT, 32'sd1, 4'd0);
    send_beat(OP_READ, 32'sd0, 4'd15);
    send_beat(OP_DELETE, 32'sd0, 4'd15);
    send_beat(OP_DELETE, 32'sd0, 4'd0);
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering beats. The output register fills, and the input has to stall
  // until the hold-off ends.
  task automatic test_output_hold_off();
    hold_req = 1'b1;
    repeat (24) send_beat(OP_INSERT, pick_value(), pick_position());
  endtask

  // The random part runs in phases. A phase favors inserts, favors deletes,
  // or keeps them balanced, so the store swings between empty and full many
  // times. Reads are mixed in throughout, and the unused opcode is rare.
  task automatic test_random_ops();
    int ins_pct;
    int r;
    logic [OP_W-1:0] op;
    ins_pct = 40;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 65;
          1: ins_pct = 20;
          default: ins_pct = 40;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 2)
        op = OP_UNUSED;
      else if (r < 2 + ins_pct)
        op = OP_INSERT;
      else if (r % 2 == 0)
        op = OP_DELETE;
      else
        op = OP_READ;
      send_beat(op, (op == OP_INSERT) ? pick_value() : $signed($urandom()),
                (op == OP_INSERT) ? POS_W'($urandom_range(0, 15)) : pick_position());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_store();
    test_extreme_values();
    test_full_store();
    test_output_hold_off();
    test_random_ops();

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
